// ===== hw/rtl/sgirle_pkg.sv =====
// ----------------------------------------------------------------------------
// sgirle_pkg
// Shared widths, codes and state types for the run-length row decoder.
// ----------------------------------------------------------------------------
package sgirle_pkg;

  localparam int LANES      = 8;
  localparam int PIX_W      = 8;
  localparam int PACK_W     = 64;
  localparam int PCNT_W     = 4;
  localparam int TAKE_W     = $clog2(LANES + 1);
  localparam int ROW_W      = 16;
  localparam int RCNT_W     = 7;

  localparam logic [PIX_W-1:0] COUNT_MASK   = 8'h7f;
  localparam logic [PIX_W-1:0] LITERAL_FLAG = 8'h80;

  // what the next accepted byte means
  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_RUN     = 2'd2
  } decode_mode_t;

  // sequencer around the shared admit unit
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

endpackage

// ===== hw/rtl/sgirle_intf.sv =====
// ----------------------------------------------------------------------------
// sgirle channel interfaces
// Valid/ready channels for code bytes, decoded pixel results and the
// row width register write.
// ----------------------------------------------------------------------------
interface sgirle_in_if;
  logic                          valid;
  logic                          ready;
  logic [sgirle_pkg::PIX_W-1:0]  code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface sgirle_out_if;
  logic                          valid;
  logic                          ready;
  logic [sgirle_pkg::PACK_W-1:0] pixels_packed;
  logic [sgirle_pkg::PCNT_W-1:0] pixel_count;
  logic                          end_of_row;
  logic                          overflow;
  logic                          last;

  modport source (output valid, output pixels_packed, output pixel_count,
                  output end_of_row, output overflow, output last, input ready);
  modport sink   (input valid, input pixels_packed, input pixel_count,
                  input end_of_row, input overflow, input last, output ready);
endinterface

interface sgirle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sgirle_pkg::ROW_W-1:0]  row_width;

  modport source (output valid, output row_width, input ready);
  modport sink   (input valid, input row_width, output ready);
endinterface

// ===== hw/rtl/sgi_rle_row_decoder.sv =====
// ----------------------------------------------------------------------------
// sgi_rle_row_decoder
// Byte-serial decoder for 8-bit run-length image rows with a row width cap.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | request
//  ---------+-----+------------------------------------------------+---------------
//  codes    | in  | code_byte                                      | one stream byte
//  pixels   | out | pixels_packed, pixel_count, end_of_row,        | one result
//           |     | overflow, last                                 |
//  cfg      | in  | row_width                                      | one register write
//
//  run value byte: taken, then drained as ceil(count / LANES) results, one
//  result per cycle from the shared admit unit (room compare and subtract).
//  codes is held off while a run drains or the result register is full and
//  not being taken; a stall on pixels freezes the sequencer.
//  rst (synchronous) clears mode, counters, sequencer and result valid;
//  row_width returns to 65535. cfg is always ready.
// ----------------------------------------------------------------------------
module sgi_rle_row_decoder (
  input  logic         clk,
  input  logic         rst,
  sgirle_in_if.sink    codes,
  sgirle_out_if.source pixels,
  sgirle_cfg_if.sink   cfg
);
  import sgirle_pkg::*;

  // architectural state
  decode_mode_t       mode, mode_next;
  logic [RCNT_W-1:0]  remaining, remaining_next;
  logic [ROW_W-1:0]   row_pos, row_pos_next;
  logic [ROW_W-1:0]   row_width;
  logic [PIX_W-1:0]   run_byte;
  seq_state_t         seq, seq_next;

  // result register
  logic               out_valid;
  logic [PACK_W-1:0]  out_packed, out_packed_next;
  logic [TAKE_W-1:0]  out_count, out_count_next;
  logic               out_eor, out_eor_next;
  logic               out_ovf, out_ovf_next;
  logic               out_last, out_last_next;

  logic               out_free;
  logic               in_ready;
  logic               in_acc;
  logic               chunk_go;
  logic               out_load;

  // shared admit unit
  logic [ROW_W-1:0]   room;
  logic [TAKE_W-1:0]  want;
  logic [TAKE_W-1:0]  take;
  logic [TAKE_W-1:0]  chunk_n;
  logic [PIX_W-1:0]   pix_byte;
  logic [PACK_W-1:0]  packed_fill;
  logic [RCNT_W-1:0]  hdr_count;

  assign out_free  = !out_valid || pixels.ready;
  assign hdr_count = RCNT_W'(codes.code_byte & COUNT_MASK);

  // sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: begin
        if (in_acc && mode == MODE_RUN) begin
          seq_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (chunk_go && remaining == RCNT_W'(chunk_n)) begin
          seq_next = SEQ_IDLE;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    chunk_go = 1'b0;
    unique case (seq)
      SEQ_IDLE: in_ready = out_free;
      SEQ_RUN:  chunk_go = out_free;
      default: begin
        in_ready = 1'b0;
        chunk_go = 1'b0;
      end
    endcase
  end

  assign in_acc       = codes.valid && in_ready;
  assign codes.ready  = in_ready;
  assign cfg.ready    = 1'b1;

  // admit: pixels the row still takes, capped at the request
  always_comb begin
    chunk_n  = (remaining < RCNT_W'(LANES)) ? TAKE_W'(remaining) : TAKE_W'(LANES);
    want     = (seq == SEQ_RUN) ? chunk_n : TAKE_W'(1);
    room     = (row_pos < row_width) ? (row_width - row_pos) : '0;
    take     = (ROW_W'(want) < room) ? want : TAKE_W'(room);
    pix_byte = (seq == SEQ_RUN) ? run_byte : codes.code_byte;
    packed_fill = '0;
    for (int i = 0; i < LANES; i++) begin
      if (TAKE_W'(i) < take) begin
        packed_fill[PIX_W*i +: PIX_W] = pix_byte;
      end
    end
  end

  // state and result next values
  always_comb begin
    mode_next       = mode;
    remaining_next  = remaining;
    row_pos_next    = row_pos;
    out_load        = 1'b0;
    out_packed_next = '0;
    out_count_next  = '0;
    out_eor_next    = 1'b0;
    out_ovf_next    = 1'b0;
    out_last_next   = 1'b1;
    if (chunk_go) begin
      out_load        = 1'b1;
      out_packed_next = packed_fill;
      out_count_next  = take;
      out_ovf_next    = (take < chunk_n);
      out_last_next   = (remaining == RCNT_W'(chunk_n));
      row_pos_next    = row_pos + ROW_W'(take);
      remaining_next  = remaining - RCNT_W'(chunk_n);
      if (remaining == RCNT_W'(chunk_n)) begin
        mode_next = MODE_HEADER;
      end
    end else if (in_acc) begin
      unique case (mode)
        MODE_LITERAL: begin
          out_load        = 1'b1;
          out_packed_next = packed_fill;
          out_count_next  = take;
          out_ovf_next    = (take == '0);
          row_pos_next    = row_pos + ROW_W'(take);
          remaining_next  = remaining - RCNT_W'(1);
          if (remaining == RCNT_W'(1)) begin
            mode_next = MODE_HEADER;
          end
        end
        MODE_RUN: begin
          // the sequencer drains this run from here on
        end
        default: begin
          if (hdr_count == '0) begin
            out_load       = 1'b1;
            out_eor_next   = 1'b1;
            row_pos_next   = '0;
            remaining_next = '0;
            mode_next      = MODE_HEADER;
          end else begin
            remaining_next = hdr_count;
            mode_next = ((codes.code_byte & LITERAL_FLAG) != '0) ? MODE_LITERAL
                                                                  : MODE_RUN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HEADER;
      remaining <= '0;
      row_pos   <= '0;
      row_width <= '1;
      seq       <= SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      remaining <= remaining_next;
      row_pos   <= row_pos_next;
      seq       <= seq_next;
      if (cfg.valid) begin
        row_width <= cfg.row_width;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == MODE_RUN) begin
      run_byte <= codes.code_byte;
    end
    if (out_load) begin
      out_packed <= out_packed_next;
      out_count  <= out_count_next;
      out_eor    <= out_eor_next;
      out_ovf    <= out_ovf_next;
      out_last   <= out_last_next;
    end
  end

  assign pixels.valid         = out_valid;
  assign pixels.pixels_packed = out_packed;
  assign pixels.pixel_count   = PCNT_W'(out_count);
  assign pixels.end_of_row    = out_eor;
  assign pixels.overflow      = out_ovf;
  assign pixels.last          = out_last;

  // byte intake only while the sequencer is idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    codes.ready |-> seq == SEQ_IDLE)
    else $error("code byte taken while a run drains");

  a_count_lanes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= TAKE_W'(LANES))
    else $error("result holds more pixels than lanes");

  a_eor_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eor |-> out_count == '0 && out_last && !out_ovf)
    else $error("end of row result malformed");

  a_run_mode: assert property (@(posedge clk) disable iff (rst)
    seq == SEQ_RUN |-> mode == MODE_RUN && remaining != '0)
    else $error("run drain without pending run");

  a_run_enter: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == MODE_RUN |=> seq == SEQ_RUN)
    else $error("run value byte did not start the drain");

endmodule
